/* rtl/drive_board_memory_map_assert.svh */
// Assertion macros for the drive board memory map.
// Define NO_ASSERTIONS to compile them out.
`ifndef DRIVE_BOARD_MEMORY_MAP_ASSERT_SVH
`define DRIVE_BOARD_MEMORY_MAP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DBMM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`define DBMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define DBMM_ASSERT_SAME(label, ante, cons)

`define DBMM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/dbmm_pkg.sv */
`timescale 1ns / 1ps

package dbmm_pkg;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int ROM_W     = 14;
    localparam int REG_W     = 4;

    localparam logic [3:0] PAGE_LED  = 4'hF;
    localparam logic [3:0] PAGE_OPEN = 4'hE;
    localparam int         WE_BIT    = 5;

    localparam logic [1:0] WIN_LOW  = 2'b01;
    localparam logic [1:0] WIN_HIGH = 2'b11;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [2:0] {
        TGT_RAM  = 3'd0,
        TGT_ROM  = 3'd1,
        TGT_SVIA = 3'd2,
        TGT_SCSI = 3'd3,
        TGT_PPI  = 3'd4,
        TGT_RTC  = 3'd5,
        TGT_DROP = 3'd6
    } t_target;

    typedef struct packed {
        t_target             target;
        logic [REG_W-1:0]    reg_idx;
        logic [ROM_W-1:0]    rom_off;
        logic [ADDR_W-1:0]   ram_addr;
        logic                ram_we;
        logic                ram_re;
        logic [DATA_W-1:0]   led_next;
    } t_dec;

endpackage

/* rtl/dbmm_ram.sv */
`timescale 1ns / 1ps

module dbmm_ram
    import dbmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:RAM_DEPTH-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dbmm_decode.sv */
`timescale 1ns / 1ps

module dbmm_decode
    import dbmm_pkg::*;
(
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_ram_map,
    input  logic              i_rom_enable,
    input  logic [DATA_W-1:0] i_led,
    output t_dec              o_dec
);

    logic [3:0] quarter;
    logic [3:0] page;
    logic       wr;
    logic       we_ok;

    assign quarter = i_address[15:12];
    assign page    = i_address[11:8];
    assign wr      = (i_kind == KIND_WRITE);

    always_comb begin
        o_dec.target   = TGT_RAM;
        o_dec.reg_idx  = '0;
        o_dec.rom_off  = '0;
        o_dec.ram_addr = i_address;
        o_dec.ram_we   = 1'b0;
        o_dec.ram_re   = 1'b0;
        o_dec.led_next = i_led;
        we_ok          = 1'b1;

        if (quarter[3:2] == 2'b01) begin
            o_dec.ram_addr = {(i_ram_map ? WIN_LOW : WIN_HIGH), i_address[13:0]};
        end else if (quarter == 4'h8) begin
            case (page)
                4'h0, 4'h1: begin
                    o_dec.target  = TGT_SVIA;
                    o_dec.reg_idx = i_address[3:0];
                end
                4'h4, 4'h5: begin
                    o_dec.target  = TGT_SCSI;
                    o_dec.reg_idx = i_address[3:0];
                end
                4'h8, 4'h9: begin
                    o_dec.target  = TGT_PPI;
                    o_dec.reg_idx = {2'b00, i_address[1:0]};
                end
                4'hC, 4'hD: begin
                    o_dec.target  = TGT_RTC;
                    o_dec.reg_idx = i_address[3:0];
                end
                default: begin
                    // The LED page is always stored; the open page ignores the latch.
                    if (wr) begin
                        if (page == PAGE_LED) begin
                            o_dec.led_next = i_write_data;
                        end else if (page != PAGE_OPEN) begin
                            we_ok = i_led[WE_BIT];
                        end
                    end
                end
            endcase
        end else if (quarter >= 4'h9) begin
            if (wr) begin
                we_ok = i_led[WE_BIT];
            end else if (quarter >= 4'hC && i_rom_enable) begin
                o_dec.target  = TGT_ROM;
                o_dec.rom_off = i_address[ROM_W-1:0];
            end
        end

        if (o_dec.target == TGT_RAM) begin
            if (wr) begin
                if (we_ok) begin
                    o_dec.ram_we = 1'b1;
                end else begin
                    o_dec.target = TGT_DROP;
                end
            end else begin
                o_dec.ram_re = 1'b1;
            end
        end
    end

endmodule

/* rtl/drive_board_memory_map.sv */
`timescale 1ns / 1ps

// Drive board memory map: address decoder with a 64 KiB RAM behind it.
// One bus access is one word on the command channel: raise start with the
// access fields while busy is low, and the word is taken at that clock edge.
// Exactly one result word follows in the next cycle, shown for a single cycle
// with o_strobe high: RAM read data, target, device register index, ROM
// offset and the LED latch value after the access. The receiver cannot hold
// results off, so it must take each word in its strobe cycle.
// Throughput is one access per cycle while busy is low: the RAM port is used
// once per access and its registered read data forms the result, so a read
// right after a write to the same byte already sees the new value.
// After reset the block clears the RAM, one byte a cycle; busy is high
// during that pass and no access is taken. The LED latch resets to zero.

module drive_board_memory_map
    import dbmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic              i_ram_map,
    input  logic              i_rom_enable,
    output logic              o_strobe,
    output logic [DATA_W-1:0] o_read_data,
    output logic [2:0]        o_target,
    output logic [REG_W-1:0]  o_register_index,
    output logic [ROM_W-1:0]  o_rom_offset,
    output logic [DATA_W-1:0] o_led_value
);

`include "drive_board_memory_map_assert.svh"

    t_dec              dec;
    logic              accept;

    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [DATA_W-1:0] r_led;
    logic              r_strobe;
    logic              r_rd_ram;
    t_target           r_target;
    logic [REG_W-1:0]  r_reg_idx;
    logic [ROM_W-1:0]  r_rom_off;
    logic [DATA_W-1:0] r_led_out;

    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    dbmm_decode u_decode (
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_ram_map    (i_ram_map),
        .i_rom_enable (i_rom_enable),
        .i_led        (r_led),
        .o_dec        (dec)
    );

    assign busy   = r_clr_active;
    assign accept = start && !busy;

    always_comb begin
        if (r_clr_active) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_en    = accept && (dec.ram_we || dec.ram_re);
            mem_we    = dec.ram_we;
            mem_addr  = dec.ram_addr;
            mem_wdata = i_write_data;
        end
    end

    dbmm_ram u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_led        <= '0;
            r_strobe     <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_strobe <= accept;
            if (accept) begin
                r_led <= dec.led_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_ram  <= dec.ram_re;
            r_target  <= dec.target;
            r_reg_idx <= dec.reg_idx;
            r_rom_off <= dec.rom_off;
            r_led_out <= dec.led_next;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_read_data      = r_rd_ram ? mem_rdata : '0;
    assign o_target         = r_target;
    assign o_register_index = r_reg_idx;
    assign o_rom_offset     = r_rom_off;
    assign o_led_value      = r_led_out;

    // A result word appears only in the cycle after a taken access.
    `DBMM_ASSERT_NEXT(a_strobe_follows_accept, start && !busy, o_strobe)
    `DBMM_ASSERT_NEXT(a_no_strobe_after_busy, busy, !o_strobe)
    // Once the clearing pass is over it never restarts without a reset.
    `DBMM_ASSERT_NEXT(a_clear_stays_done, !busy, !busy)
    `DBMM_ASSERT_SAME(a_read_data_only_ram, o_strobe && (o_target != TGT_RAM), o_read_data == '0)
    `DBMM_ASSERT_SAME(a_rom_offset_only_rom, o_strobe && (o_target != TGT_ROM), o_rom_offset == '0)

endmodule

/* sim/drive_board_memory_map_test.sv */
`timescale 1ns / 1ps

module drive_board_memory_map_test;
    import dbmm_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int POOL_SIZE      = 16;

    localparam logic [3:0] QTR_IO   = 4'h8;
    localparam logic [2:0] DEV_SVIA = 3'b000;
    localparam logic [2:0] DEV_SCSI = 3'b010;
    localparam logic [2:0] DEV_PPI  = 3'b100;
    localparam logic [2:0] DEV_RTC  = 3'b110;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        t_target           target;
        logic [REG_W-1:0]  reg_idx;
        logic [ROM_W-1:0]  rom_off;
        logic [DATA_W-1:0] led;
    } t_bus_result;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              ram_map;
        logic              rom_enable;
        logic              has_literal;
        t_bus_result       literal;
    } t_access;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_kind = KIND_READ;
    logic [ADDR_W-1:0] i_address = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              i_ram_map = 1'b0;
    logic              i_rom_enable = 1'b0;
    logic              o_strobe;
    logic [DATA_W-1:0] o_read_data;
    logic [2:0]        o_target;
    logic [REG_W-1:0]  o_register_index;
    logic [ROM_W-1:0]  o_rom_offset;
    logic [DATA_W-1:0] o_led_value;

    // Literal expectation that travels with the word being driven.
    logic              drv_has_literal = 1'b0;
    t_bus_result       drv_literal = '0;

    logic [DATA_W-1:0] ram_shadow [0:RAM_DEPTH-1];
    logic [DATA_W-1:0] led_shadow = '0;
    t_bus_result       pending_results [$];
    t_access           directed_rows [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    int                mismatch_count = 0;
    int                quiet_cycles = 0;
    int                burst_left = 0;

    drive_board_memory_map dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .i_ram_map        (i_ram_map),
        .i_rom_enable     (i_rom_enable),
        .o_strobe         (o_strobe),
        .o_read_data      (o_read_data),
        .o_target         (o_target),
        .o_register_index (o_register_index),
        .o_rom_offset     (o_rom_offset),
        .o_led_value      (o_led_value)
    );

    always #5 i_clk = ~i_clk;

    // Decodes one bus access and applies it to the shadow RAM and latch.
    function automatic t_bus_result decode_access(t_access a);
        t_bus_result       res;
        logic [ADDR_W-1:0] ram_addr;
        logic              we;
        res = '0;
        res.target = TGT_RAM;
        ram_addr = a.addr;
        we = 1'b1;
        if (a.addr[15:14] == WIN_LOW) begin
            ram_addr = {a.ram_map ? WIN_LOW : WIN_HIGH, a.addr[13:0]};
        end else if (a.addr[15:12] == QTR_IO) begin
            case (a.addr[11:9])
                DEV_SVIA: begin
                    res.target = TGT_SVIA;
                    res.reg_idx = a.addr[3:0];
                end
                DEV_SCSI: begin
                    res.target = TGT_SCSI;
                    res.reg_idx = a.addr[3:0];
                end
                DEV_PPI: begin
                    res.target = TGT_PPI;
                    res.reg_idx = {2'b00, a.addr[1:0]};
                end
                DEV_RTC: begin
                    res.target = TGT_RTC;
                    res.reg_idx = a.addr[3:0];
                end
                default: begin
                    if (a.kind == KIND_WRITE) begin
                        if (a.addr[11:8] == PAGE_LED)
                            led_shadow = a.data;
                        else if (a.addr[11:8] != PAGE_OPEN)
                            we = led_shadow[WE_BIT];
                    end
                end
            endcase
        end else if (a.addr[15]) begin
            if (a.kind == KIND_WRITE) begin
                we = led_shadow[WE_BIT];
            end else if (a.addr[15:14] == WIN_HIGH && a.rom_enable) begin
                res.target = TGT_ROM;
                res.rom_off = a.addr[13:0];
            end
        end
        if (res.target == TGT_RAM) begin
            if (a.kind == KIND_WRITE) begin
                if (we)
                    ram_shadow[ram_addr] = a.data;
                else
                    res.target = TGT_DROP;
            end else begin
                res.read_data = ram_shadow[ram_addr];
            end
        end
        res.led = led_shadow;
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bus_result want;
        t_bus_result model;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing expected: target 0x%0h, data 0x%0h",
                         $time, o_target, o_read_data);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("target", want.target, o_target);
                check_field("register_index", want.reg_idx, o_register_index);
                check_field("rom_offset", want.rom_off, o_rom_offset);
                check_field("led_value", want.led, o_led_value);
            end
        end
        if (i_rst_n && start && !busy) begin
            model = decode_access({i_kind, i_address, i_write_data, i_ram_map,
                                   i_rom_enable, 1'b0, t_bus_result'('0)});
            pending_results.push_back(drv_has_literal ? drv_literal : model);
        end
    end

    // The clearing pass after reset is the longest quiet stretch.
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic add_row(logic kind, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                           logic ram_map, logic rom_enable);
        directed_rows.push_back({kind, addr, data, ram_map, rom_enable, 1'b0,
                                 t_bus_result'('0)});
    endtask

    task automatic add_checked_row(logic kind, logic [ADDR_W-1:0] addr,
                                   logic [DATA_W-1:0] data, logic ram_map, logic rom_enable,
                                   logic [DATA_W-1:0] rdata, t_target tgt,
                                   logic [REG_W-1:0] reg_idx, logic [ROM_W-1:0] rom_off,
                                   logic [DATA_W-1:0] led);
        t_bus_result lit;
        lit = '{read_data: rdata, target: tgt, reg_idx: reg_idx, rom_off: rom_off, led: led};
        directed_rows.push_back({kind, addr, data, ram_map, rom_enable, 1'b1, lit});
    endtask

    // Drives one word at the falling edge and holds it until busy is low,
    // so the word is taken at the following rising edge.
    task automatic send_access(t_access a);
        @(negedge i_clk);
        i_kind = a.kind;
        i_address = a.addr;
        i_write_data = a.data;
        i_ram_map = a.ram_map;
        i_rom_enable = a.rom_enable;
        drv_has_literal = a.has_literal;
        drv_literal = a.literal;
        start = 1'b1;
        while (busy)
            @(negedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    function automatic t_access random_access();
        t_access a;
        int      pick;
        a = '0;
        if ($urandom_range(0, 7) == 0)
            addr_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom());
        pick = $urandom_range(0, 15);
        case (pick)
            0, 1, 2, 3: a.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            4: a.addr = {WIN_LOW, addr_pool[$urandom_range(0, POOL_SIZE - 1)][13:0]};
            5: a.addr = {WIN_HIGH, addr_pool[$urandom_range(0, POOL_SIZE - 1)][13:0]};
            6, 7: begin
                case ($urandom_range(0, 3))
                    0: a.addr[11:9] = DEV_SVIA;
                    1: a.addr[11:9] = DEV_SCSI;
                    2: a.addr[11:9] = DEV_PPI;
                    default: a.addr[11:9] = DEV_RTC;
                endcase
                a.addr[15:12] = QTR_IO;
                a.addr[8:0] = 9'($urandom());
            end
            8, 9: a.addr = {QTR_IO, $urandom_range(0, 1) ? PAGE_LED : PAGE_OPEN,
                            8'($urandom())};
            10: a.addr = {WIN_HIGH, 14'($urandom())};
            default: a.addr = 16'($urandom());
        endcase
        a.kind = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
        a.data = 8'($urandom());
        a.ram_map = 1'($urandom());
        a.rom_enable = 1'($urandom());
        return a;
    endfunction

    initial begin
        t_access a;
        foreach (ram_shadow[k])
            ram_shadow[k] = '0;
        foreach (addr_pool[k])
            addr_pool[k] = 16'($urandom());

        add_checked_row(KIND_READ,  16'h0000, 8'h00, 1'b0, 1'b0, 8'h00, TGT_RAM,  4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_WRITE, 16'h0000, 8'hFF, 1'b0, 1'b0, 8'h00, TGT_RAM,  4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'h0000, 8'h00, 1'b0, 1'b0, 8'hFF, TGT_RAM,  4'h0, 14'h0, 8'h00);
        // The write enable is clear after reset, so protected writes are dropped.
        add_checked_row(KIND_WRITE, 16'hFFFF, 8'hA5, 1'b0, 1'b0, 8'h00, TGT_DROP, 4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_WRITE, 16'h9000, 8'h11, 1'b0, 1'b0, 8'h00, TGT_DROP, 4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_WRITE, 16'h8E00, 8'h5A, 1'b0, 1'b0, 8'h00, TGT_RAM,  4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'h8E00, 8'h00, 1'b0, 1'b0, 8'h5A, TGT_RAM,  4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'h8000, 8'h00, 1'b0, 1'b0, 8'h00, TGT_SVIA, 4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'h810F, 8'h00, 1'b1, 1'b1, 8'h00, TGT_SVIA, 4'hF, 14'h0, 8'h00);
        add_checked_row(KIND_WRITE, 16'h8407, 8'h33, 1'b0, 1'b0, 8'h00, TGT_SCSI, 4'h7, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'h85FF, 8'h00, 1'b0, 1'b0, 8'h00, TGT_SCSI, 4'hF, 14'h0, 8'h00);
        add_checked_row(KIND_WRITE, 16'h88FF, 8'h44, 1'b0, 1'b0, 8'h00, TGT_PPI,  4'h3, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'h8902, 8'h00, 1'b0, 1'b0, 8'h00, TGT_PPI,  4'h2, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'h8C0A, 8'h00, 1'b0, 1'b0, 8'h00, TGT_RTC,  4'hA, 14'h0, 8'h00);
        add_checked_row(KIND_WRITE, 16'h8DF1, 8'h77, 1'b0, 1'b0, 8'h00, TGT_RTC,  4'h1, 14'h0, 8'h00);
        add_checked_row(KIND_READ,  16'hC000, 8'h00, 1'b0, 1'b1, 8'h00, TGT_ROM,  4'h0, 14'h0000, 8'h00);
        add_checked_row(KIND_READ,  16'hFFFF, 8'h00, 1'b0, 1'b1, 8'h00, TGT_ROM,  4'h0, 14'h3FFF, 8'h00);
        add_checked_row(KIND_READ,  16'hFFFF, 8'h00, 1'b0, 1'b0, 8'h00, TGT_RAM,  4'h0, 14'h0, 8'h00);
        add_checked_row(KIND_WRITE, 16'h8F20, 8'h20, 1'b0, 1'b0, 8'h00, TGT_RAM,  4'h0, 14'h0, 8'h20);
        add_checked_row(KIND_WRITE, 16'hFFFF, 8'hA5, 1'b0, 1'b0, 8'h00, TGT_RAM,  4'h0, 14'h0, 8'h20);
        add_row(KIND_READ,  16'h7FFF, 8'h00, 1'b0, 1'b0);
        add_row(KIND_WRITE, 16'h4000, 8'h3C, 1'b1, 1'b0);
        add_row(KIND_READ,  16'h4000, 8'h00, 1'b0, 1'b0);
        add_row(KIND_READ,  16'h4000, 8'h00, 1'b1, 1'b0);
        add_checked_row(KIND_WRITE, 16'h8F00, 8'hDF, 1'b0, 1'b0, 8'h00, TGT_RAM,  4'h0, 14'h0, 8'hDF);
        add_checked_row(KIND_WRITE, 16'hA000, 8'h01, 1'b0, 1'b0, 8'h00, TGT_DROP, 4'h0, 14'h0, 8'hDF);
        add_row(KIND_READ,  16'h8F00, 8'h00, 1'b0, 1'b0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            send_access(directed_rows[k]);
            pace_sender();
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            a = random_access();
            send_access(a);
            pace_sender();
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
